FILE: hdl/qpdpc_pkg.sv
// Shared types and constants for the quadrature PD position controller.
// Holds item codes, register indexes, reset values and the beat structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpdpc_pkg;

    // Fixed field widths
    localparam int FUNC_W     = 2;
    localparam int GAIN_W     = 12;
    localparam int DUTY_W     = 7;
    localparam int REF_W      = 16;
    localparam int POS_OUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Classified operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_SAMPLE = 2'd0;
    localparam t_op OP_TICK   = 2'd1;
    localparam t_op OP_START  = 2'd2;
    localparam t_op OP_NOP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 3'd4;

    // Register reset values (gains are Q4.8: 0.4 and 0.2)
    localparam logic [REF_W-1:0]  REF_RESET      = 16'd0;
    localparam logic [GAIN_W-1:0] KP_RESET       = 12'd102;
    localparam logic [GAIN_W-1:0] KD_RESET       = 12'd51;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RESET = 7'd3;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 7'd75;

    // Command beat from front to back
    typedef struct packed {
        t_op  op;
        logic a;
        logic b;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [DUTY_W-1:0]           duty;
        logic                        direction;
        logic                        motor_on;
        logic                        running;
        logic signed [POS_OUT_W-1:0] position;
        logic                        encoder_error;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/quadrature_pd_position_controller.sv
// Top level of the quadrature encoder PD position controller.
// Depends on qpdpc_pkg, qpdpc_front, qpdpc_back and qpdpc_queue.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------
//  input     | i_func, i_chan_a, i_chan_b              | push / full
//  result    | o_duty .. o_encoder_error               | empty / pop
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data         | write, no wait
//
// Samples, starts and idle ticks never stall in the back end; only a full
// result queue holds them. A running tick waits when it directly follows
// another running tick, a config write or reset: the gain products are stale.
// Each result enters the result queue when the back end takes its command.
// Synchronous reset empties both queues, clears state, loads register defaults.
// Two-entry queues on each side let input and result sides stall apart.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_pd_position_controller #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [qpdpc_pkg::FUNC_W-1:0]        i_func,
    input  wire logic                                i_chan_a,
    input  wire logic                                i_chan_b,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [qpdpc_pkg::DUTY_W-1:0]             o_duty,
    output logic                                     o_direction,
    output logic                                     o_motor_on,
    output logic                                     o_running,
    output logic signed [qpdpc_pkg::POS_OUT_W-1:0]   o_position,
    output logic                                     o_encoder_error,
    input  wire logic                                i_cfg_we,
    input  wire logic [qpdpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qpdpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int RES_W = $bits(qpdpc_pkg::t_result);

    qpdpc_pkg::t_cmd    cmd;
    qpdpc_pkg::t_result res_in, res_out;
    logic               cmd_valid, cmd_take, res_push, res_full;
    logic [RES_W-1:0]   res_bits;

    qpdpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_func   (i_func),
        .i_chan_a (i_chan_a),
        .i_chan_b (i_chan_b),
        .o_full   (full),
        .i_take   (cmd_take),
        .o_cmd    (cmd),
        .o_valid  (cmd_valid)
    );

    qpdpc_back #(
        .PW (POSITION_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_take      (cmd_take),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    qpdpc_queue #(
        .W     (RES_W),
        .DEPTH (qpdpc_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    // Unpack the oldest result beat
    assign res_out         = qpdpc_pkg::t_result'(res_bits);
    assign o_duty          = res_out.duty;
    assign o_direction     = res_out.direction;
    assign o_motor_on      = res_out.motor_on;
    assign o_running       = res_out.running;
    assign o_position      = res_out.position;
    assign o_encoder_error = res_out.encoder_error;

endmodule

`default_nettype wire

FILE: hdl/qpdpc_queue.sv
// Small register queue with full/empty flags.
// Used for the command queue and the result queue; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module qpdpc_queue #(
    parameter int W     = 4,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Store an entry on push
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/qpdpc_front.sv
// Front end: classifies input items into commands and queues them.
// Depends on qpdpc_pkg and qpdpc_queue.
`timescale 1ns / 1ps
`default_nettype none

module qpdpc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [qpdpc_pkg::FUNC_W-1:0]   i_func,
    input  wire logic                           i_chan_a,
    input  wire logic                           i_chan_b,
    output logic                                o_full,
    input  wire logic                           i_take,
    output qpdpc_pkg::t_cmd                     o_cmd,
    output logic                                o_valid
);

    localparam int CMD_W = $bits(qpdpc_pkg::t_cmd);

    qpdpc_pkg::t_cmd  cls_cmd;
    logic [CMD_W-1:0] q_data;
    logic             q_empty;

    // Classify the incoming beat; channel levels matter only for samples
    always_comb begin
        cls_cmd.a = 1'b0;
        cls_cmd.b = 1'b0;
        case (i_func)
            qpdpc_pkg::FUNC_SAMPLE: begin
                cls_cmd.op = qpdpc_pkg::OP_SAMPLE;
                cls_cmd.a  = i_chan_a;
                cls_cmd.b  = i_chan_b;
            end
            qpdpc_pkg::FUNC_TICK:  cls_cmd.op = qpdpc_pkg::OP_TICK;
            qpdpc_pkg::FUNC_START: cls_cmd.op = qpdpc_pkg::OP_START;
            default:               cls_cmd.op = qpdpc_pkg::OP_NOP;
        endcase
    end

    qpdpc_queue #(
        .W     (CMD_W),
        .DEPTH (qpdpc_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_cmd),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_cmd   = qpdpc_pkg::t_cmd'(q_data);
    assign o_valid = !q_empty;

endmodule

`default_nettype wire

FILE: hdl/qpdpc_back.sv
// Back end: configuration registers, encoder count and PD duty law.
// Depends on qpdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpdpc_back #(
    parameter int PW = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [qpdpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [qpdpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire qpdpc_pkg::t_cmd                    i_cmd,
    input  wire logic                               i_cmd_valid,
    output logic                                    o_take,
    output qpdpc_pkg::t_result                      o_res,
    output logic                                    o_res_push,
    input  wire logic                               i_res_full
);

    localparam int GW     = qpdpc_pkg::GAIN_W;
    localparam int DW     = qpdpc_pkg::DUTY_W;
    localparam int RW     = qpdpc_pkg::REF_W;
    localparam int OW     = qpdpc_pkg::POS_OUT_W;
    localparam int PROD_W = GW + PW;
    localparam int VAL_W  = PROD_W + 1;
    localparam int QUOT_W = PROD_W - qpdpc_pkg::FRAC_BITS;

    // Configuration registers
    logic [RW-1:0] r_ref;
    logic [GW-1:0] r_kp, r_kd;
    logic [DW-1:0] r_dmin, r_dmax;

    // Controller state
    logic [PW-1:0] r_cnt, r_cur, r_prev;
    logic [PW-1:0] n_cnt, n_cur, n_prev;
    logic          r_last_a, r_last_b, r_err, r_run, r_drv, r_dir;
    logic          n_last_a, n_last_b, n_err, n_run, n_drv, n_dir;
    logic [DW-1:0] r_duty, n_duty;

    // Product stage
    logic [PROD_W-1:0] r_prod_p, r_prod_d;
    logic              r_prod_ok, n_prod_ok;

    logic [PW-1:0]     ref_pw;
    logic [PW:0]       diff_e, diff_v, neg_e, neg_v;
    logic [PW-1:0]     abs_e, abs_v;
    logic [VAL_W-1:0]  val;
    logic [QUOT_W-1:0] quot, dmin_ext, dmax_ext, d_low;
    logic [DW-1:0]     tick_duty;
    logic              cnt_lt, cnt_gt;
    logic              stall, fire, run_tick;
    logic [OW-1:0]     pos_out;

    // Target read as PW bits and count as OW bits: low bits, or zero-extended
    generate
        if (PW <= RW) begin : g_ref_trunc
            assign ref_pw = r_ref[PW-1:0];
        end else begin : g_ref_ext
            assign ref_pw = {{(PW - RW){1'b0}}, r_ref};
        end
        if (PW >= OW) begin : g_pos_trunc
            assign pos_out = n_cnt[OW-1:0];
        end else begin : g_pos_ext
            assign pos_out = {{(OW - PW){1'b0}}, n_cnt};
        end
    endgenerate

    // Error and speed magnitudes
    assign diff_e = {ref_pw[PW-1], ref_pw} - {r_cur[PW-1], r_cur};
    assign diff_v = {r_prev[PW-1], r_prev} - {r_cur[PW-1], r_cur};
    assign neg_e  = -diff_e;
    assign neg_v  = -diff_v;
    assign abs_e  = diff_e[PW] ? neg_e[PW-1:0] : diff_e[PW-1:0];
    assign abs_v  = diff_v[PW] ? neg_v[PW-1:0] : diff_v[PW-1:0];

    // Register both gain products each cycle
    always_ff @(posedge i_clk) begin
        r_prod_p <= {{PW{1'b0}}, r_kp} * {{GW{1'b0}}, abs_e};
        r_prod_d <= {{PW{1'b0}}, r_kd} * {{GW{1'b0}}, abs_v};
    end

    // Duty law from registered products: clamp low, then high
    assign val       = {1'b0, r_prod_p} - {1'b0, r_prod_d};
    assign quot      = val[PROD_W-1:qpdpc_pkg::FRAC_BITS];
    assign dmin_ext  = {{(QUOT_W - DW){1'b0}}, r_dmin};
    assign dmax_ext  = {{(QUOT_W - DW){1'b0}}, r_dmax};
    assign d_low     = (val[VAL_W-1] || (quot < dmin_ext)) ? dmin_ext : quot;
    assign tick_duty = (d_low > dmax_ext) ? r_dmax : d_low[DW-1:0];

    assign cnt_lt = $signed(r_cnt) < $signed(ref_pw);
    assign cnt_gt = $signed(r_cnt) > $signed(ref_pw);

    // Hold a running tick until the products reflect the current samples
    assign stall      = (i_cmd.op == qpdpc_pkg::OP_TICK) && r_run && !r_prod_ok;
    assign fire       = i_cmd_valid && !i_res_full && !stall;
    assign run_tick   = fire && (i_cmd.op == qpdpc_pkg::OP_TICK) && r_run;
    assign o_take     = fire;
    assign o_res_push = fire;
    assign n_prod_ok  = !run_tick && !i_cfg_we;

    // Apply one command
    always_comb begin
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_last_a = r_last_a;
        n_last_b = r_last_b;
        n_err    = r_err;
        n_run    = r_run;
        n_drv    = r_drv;
        n_dir    = r_dir;
        n_duty   = r_duty;
        if (fire) begin
            case (i_cmd.op)
                qpdpc_pkg::OP_SAMPLE: begin
                    n_cnt = r_cnt + {{(PW - 1){1'b0}}, i_cmd.a ^ r_last_b}
                                  - {{(PW - 1){1'b0}}, i_cmd.b ^ r_last_a};
                    if ((i_cmd.a != r_last_a) && (i_cmd.b != r_last_b)) begin
                        n_err = 1'b1;
                    end
                    n_last_a = i_cmd.a;
                    n_last_b = i_cmd.b;
                end
                qpdpc_pkg::OP_TICK: begin
                    if (r_run) begin
                        n_duty = tick_duty;
                        if (cnt_lt) begin
                            n_dir = 1'b0;
                        end else if (cnt_gt) begin
                            n_dir = 1'b1;
                        end else begin
                            n_drv  = 1'b0;
                            n_run  = 1'b0;
                            n_duty = '0;
                        end
                        n_prev = r_cur;
                        n_cur  = r_cnt;
                    end
                end
                qpdpc_pkg::OP_START: begin
                    n_run = 1'b1;
                    n_drv = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result beat reports state after the command
    always_comb begin
        o_res.duty          = n_duty;
        o_res.direction     = n_dir;
        o_res.motor_on      = n_drv;
        o_res.running       = n_run;
        o_res.position      = pos_out;
        o_res.encoder_error = n_err;
    end

    // Controller state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_last_a  <= 1'b0;
            r_last_b  <= 1'b0;
            r_err     <= 1'b0;
            r_run     <= 1'b0;
            r_drv     <= 1'b0;
            r_dir     <= 1'b0;
            r_duty    <= '0;
            r_prod_ok <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_prev    <= n_prev;
            r_last_a  <= n_last_a;
            r_last_b  <= n_last_b;
            r_err     <= n_err;
            r_run     <= n_run;
            r_drv     <= n_drv;
            r_dir     <= n_dir;
            r_duty    <= n_duty;
            r_prod_ok <= n_prod_ok;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= qpdpc_pkg::REF_RESET;
            r_kp   <= qpdpc_pkg::KP_RESET;
            r_kd   <= qpdpc_pkg::KD_RESET;
            r_dmin <= qpdpc_pkg::DUTY_MIN_RESET;
            r_dmax <= qpdpc_pkg::DUTY_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qpdpc_pkg::CFG_REF:      r_ref  <= i_cfg_data[RW-1:0];
                qpdpc_pkg::CFG_KP:       r_kp   <= i_cfg_data[GW-1:0];
                qpdpc_pkg::CFG_KD:       r_kd   <= i_cfg_data[GW-1:0];
                qpdpc_pkg::CFG_DUTY_MIN: r_dmin <= i_cfg_data[DW-1:0];
                qpdpc_pkg::CFG_DUTY_MAX: r_dmax <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/qpdpc_checker.sv
// Port-level checks for the position controller, bound to the top level.
// Depends on quadrature_pd_position_controller port names only.
`timescale 1ns / 1ps
`default_nettype none

module qpdpc_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [6:0]        o_duty,
    input wire logic              o_motor_on,
    input wire logic              o_running,
    input wire logic signed [15:0] o_position
);

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // Drive enable and run flag move together
    a_run_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_running == o_motor_on))
        else $error("running and motor_on disagree");

    // A stopped motor reports zero duty
    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_running) |-> (o_duty == 7'd0))
        else $error("nonzero duty while not running");

    // A waiting result beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_position)))
        else $error("result beat changed while waiting");

endmodule

bind quadrature_pd_position_controller qpdpc_checker u_chk (.*);

`default_nettype wire

FILE: tb/quadrature_pd_position_controller_tb.sv
// Self-checking testbench for quadrature_pd_position_controller: a status predictor
// tracks the encoder count and the PD duty law and checks every result beat.
// Depends on qpdpc_pkg and the quadrature_pd_position_controller top level.
`timescale 1ns / 1ps

module quadrature_pd_position_controller_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 480;
    localparam logic signed [qpdpc_pkg::REF_W-1:0] REF_TOP    = 16'sh7FFF;
    localparam logic signed [qpdpc_pkg::REF_W-1:0] REF_BOTTOM = 16'sh8000;
    localparam logic signed [qpdpc_pkg::REF_W-1:0] REF_BELOW  = -16'sd3;
    localparam logic signed [qpdpc_pkg::REF_W-1:0] WALK_FLOOR = -16'sd6;

    // Predicts the output status after each command beat and holds it until checked
    class pd_status_board;
        logic [qpdpc_pkg::REF_W-1:0]     ref_pos;
        logic [qpdpc_pkg::GAIN_W-1:0]    kp;
        logic [qpdpc_pkg::GAIN_W-1:0]    kd;
        logic [qpdpc_pkg::DUTY_W-1:0]    dmin;
        logic [qpdpc_pkg::DUTY_W-1:0]    dmax;
        logic [qpdpc_pkg::POS_OUT_W-1:0] count;
        logic [qpdpc_pkg::POS_OUT_W-1:0] cur;
        logic [qpdpc_pkg::POS_OUT_W-1:0] prev;
        logic [qpdpc_pkg::DUTY_W-1:0]    duty;
        bit                              last_a;
        bit                              last_b;
        bit                              enc_fault;
        bit                              run;
        bit                              drive;
        bit                              dir;
        qpdpc_pkg::t_result              due_status[$];
        int                              faults;

        function new();
            ref_pos   = qpdpc_pkg::REF_RESET;
            kp        = qpdpc_pkg::KP_RESET;
            kd        = qpdpc_pkg::KD_RESET;
            dmin      = qpdpc_pkg::DUTY_MIN_RESET;
            dmax      = qpdpc_pkg::DUTY_MAX_RESET;
            count     = '0;
            cur       = '0;
            prev      = '0;
            duty      = '0;
            last_a    = 1'b0;
            last_b    = 1'b0;
            enc_fault = 1'b0;
            run       = 1'b0;
            drive     = 1'b0;
            dir       = 1'b0;
            faults    = 0;
        endfunction

        function void write_reg(logic [qpdpc_pkg::CFG_IDX_W-1:0] idx,
                                logic [qpdpc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                qpdpc_pkg::CFG_REF:      ref_pos = data[qpdpc_pkg::REF_W-1:0];
                qpdpc_pkg::CFG_KP:       kp      = data[qpdpc_pkg::GAIN_W-1:0];
                qpdpc_pkg::CFG_KD:       kd      = data[qpdpc_pkg::GAIN_W-1:0];
                qpdpc_pkg::CFG_DUTY_MIN: dmin    = data[qpdpc_pkg::DUTY_W-1:0];
                qpdpc_pkg::CFG_DUTY_MAX: dmax    = data[qpdpc_pkg::DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply the PD law, pick the direction or stop, then shift the samples
        function void run_tick();
            longint err_mag;
            longint vel_mag;
            longint val;
            longint level;
            err_mag = longint'($signed(ref_pos)) - longint'($signed(cur));
            vel_mag = longint'($signed(prev)) - longint'($signed(cur));
            if (err_mag < 0) err_mag = -err_mag;
            if (vel_mag < 0) vel_mag = -vel_mag;
            val = longint'(kp) * err_mag - longint'(kd) * vel_mag;
            if (val < 0) begin
                level = longint'(dmin);
            end else begin
                level = val >>> qpdpc_pkg::FRAC_BITS;
                if (level < longint'(dmin)) level = longint'(dmin);
            end
            // max is applied last, so it wins when min sits above it
            if (level > longint'(dmax)) level = longint'(dmax);
            duty = level[qpdpc_pkg::DUTY_W-1:0];
            if ($signed(count) < $signed(ref_pos)) begin
                dir = 1'b0;
            end else if ($signed(count) > $signed(ref_pos)) begin
                dir = 1'b1;
            end else begin
                drive = 1'b0;
                run   = 1'b0;
                duty  = '0;
            end
            prev = cur;
            cur  = count;
        endfunction

        // Advance the state by one accepted command beat and queue the status it gives
        function void take_command(logic [qpdpc_pkg::FUNC_W-1:0] func, bit a, bit b);
            qpdpc_pkg::t_result want;
            case (func)
                qpdpc_pkg::FUNC_SAMPLE: begin
                    if (a ^ last_b) count = count + 16'd1;
                    if (b ^ last_a) count = count - 16'd1;
                    if (a != last_a && b != last_b) enc_fault = 1'b1;
                    last_a = a;
                    last_b = b;
                end
                qpdpc_pkg::FUNC_TICK: begin
                    if (run) run_tick();
                end
                qpdpc_pkg::FUNC_START: begin
                    run   = 1'b1;
                    drive = 1'b1;
                end
                default: ;
            endcase
            want.duty          = duty;
            want.direction     = dir;
            want.motor_on      = drive;
            want.running       = run;
            want.position      = count;
            want.encoder_error = enc_fault;
            due_status.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                faults++;
                if (faults <= 10)
                    $display("status mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // Compare one result beat with the oldest predicted status
        function void check_status(qpdpc_pkg::t_result got);
            qpdpc_pkg::t_result want;
            if (due_status.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result beat with no command outstanding, position %0h",
                             got.position);
                return;
            end
            want = due_status.pop_front();
            compare_field("duty", 16'(want.duty), 16'(got.duty));
            compare_field("direction", 16'(want.direction), 16'(got.direction));
            compare_field("motor_on", 16'(want.motor_on), 16'(got.motor_on));
            compare_field("running", 16'(want.running), 16'(got.running));
            compare_field("position", want.position, got.position);
            compare_field("encoder_error", 16'(want.encoder_error),
                          16'(got.encoder_error));
        endfunction
    endclass

    logic                                   i_clk      = 1'b0;
    logic                                   i_rst_n    = 1'b0;
    logic                                   push       = 1'b0;
    logic                                   pop        = 1'b0;
    logic [qpdpc_pkg::FUNC_W-1:0]           i_func     = '0;
    logic                                   i_chan_a   = 1'b0;
    logic                                   i_chan_b   = 1'b0;
    logic                                   i_cfg_we   = 1'b0;
    logic [qpdpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx  = '0;
    logic [qpdpc_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                                   full;
    logic                                   empty;
    logic [qpdpc_pkg::DUTY_W-1:0]           o_duty;
    logic                                   o_direction;
    logic                                   o_motor_on;
    logic                                   o_running;
    logic signed [qpdpc_pkg::POS_OUT_W-1:0] o_position;
    logic                                   o_encoder_error;

    pd_status_board board;
    bit calm = 1'b0;
    logic signed [qpdpc_pkg::REF_W-1:0] target_pos = '0;
    int unsigned cycles = 0;

    quadrature_pd_position_controller dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_func,
        .i_chan_a,
        .i_chan_b,
        .empty,
        .pop,
        .o_duty,
        .o_direction,
        .o_motor_on,
        .o_running,
        .o_position,
        .o_encoder_error,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** quadrature_pd_position_controller: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm) return 0;
        return int'($urandom_range(15, 0));
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(1, 0));
    endfunction

    function automatic logic [qpdpc_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(4, 0))
            0: return '0;
            1: return '1;
            2: return qpdpc_pkg::GAIN_W'($urandom_range(400, 0));
            default: return qpdpc_pkg::GAIN_W'($urandom_range(4095, 0));
        endcase
    endfunction

    function automatic logic [qpdpc_pkg::DUTY_W-1:0] pick_duty();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return 7'd99;
            default: return qpdpc_pkg::DUTY_W'($urandom_range(99, 0));
        endcase
    endfunction

    // Present one command beat after a random gap and hold it until taken
    task automatic send(logic [qpdpc_pkg::FUNC_W-1:0] func, bit a, bit b);
        int gap;
        bit taken;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_func   <= func;
        i_chan_a <= a;
        i_chan_b <= b;
        do begin
            @(negedge i_clk);
            taken = (full === 1'b0);
            if (taken) board.take_command(func, a, b);
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Advance the encoder one quadrature state forward or backward
    task automatic step(bit forward);
        if (forward) send(qpdpc_pkg::FUNC_SAMPLE, ~board.last_b, board.last_a);
        else send(qpdpc_pkg::FUNC_SAMPLE, board.last_b, ~board.last_a);
    endtask

    // Drop push and wait until every predicted status has been popped
    task automatic settle();
        push <= 1'b0;
        while (board.due_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [qpdpc_pkg::CFG_IDX_W-1:0] idx,
                             logic [qpdpc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Reload all registers once the block has drained
    task automatic configure(logic signed [qpdpc_pkg::REF_W-1:0] goal,
                             logic [qpdpc_pkg::GAIN_W-1:0] p,
                             logic [qpdpc_pkg::GAIN_W-1:0] d,
                             logic [qpdpc_pkg::DUTY_W-1:0] lo,
                             logic [qpdpc_pkg::DUTY_W-1:0] hi);
        settle();
        cfg_write(qpdpc_pkg::CFG_REF, goal);
        cfg_write(qpdpc_pkg::CFG_KP, qpdpc_pkg::CFG_DATA_W'(p));
        cfg_write(qpdpc_pkg::CFG_KD, qpdpc_pkg::CFG_DATA_W'(d));
        cfg_write(qpdpc_pkg::CFG_DUTY_MIN, qpdpc_pkg::CFG_DATA_W'(lo));
        cfg_write(qpdpc_pkg::CFG_DUTY_MAX, qpdpc_pkg::CFG_DATA_W'(hi));
        i_cfg_we   <= 1'b0;
        target_pos = goal;
    endtask

    // Pop side: random stalls, check each result beat as it is taken
    initial begin
        int gap;
        bit got_one;
        qpdpc_pkg::t_result seen;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                got_one = (empty === 1'b0);
                if (got_one) begin
                    seen.duty          = o_duty;
                    seen.direction     = o_direction;
                    seen.motor_on      = o_motor_on;
                    seen.running       = o_running;
                    seen.position      = o_position;
                    seen.encoder_error = o_encoder_error;
                    board.check_status(seen);
                end
                @(posedge i_clk);
            end while (!got_one);
        end
    end

    initial begin
        int picked;
        int goal;
        int roll;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset gains, idle tick, unused code, counting and a double edge
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_UNUSED, 1'b1, 1'b1);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b1, 1'b0);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b1, 1'b1);
        send(qpdpc_pkg::FUNC_START, 1'b1, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b1, 1'b1);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b0, 1'b1);
        send(qpdpc_pkg::FUNC_SAMPLE, 1'b1, 1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_START, 1'b0, 1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);

        // Directed: top target with full kp, then bottom target with min above max
        configure(REF_TOP, '1, '0, '0, 7'd99);
        send(qpdpc_pkg::FUNC_START, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        step(1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        configure(REF_BOTTOM, '0, '1, 7'd99, '0);
        step(1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        step(1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);

        // Walk the count below zero past a negative target, no stalls
        configure(REF_BELOW, qpdpc_pkg::KP_RESET, qpdpc_pkg::KD_RESET,
                  qpdpc_pkg::DUTY_MIN_RESET, qpdpc_pkg::DUTY_MAX_RESET);
        calm = 1'b1;
        send(qpdpc_pkg::FUNC_START, 1'b0, 1'b0);
        while ($signed(board.count) > WALK_FLOOR) begin
            step(1'b0);
            send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        end
        configure(REF_BOTTOM, pick_gain(), pick_gain(), pick_duty(), pick_duty());
        send(qpdpc_pkg::FUNC_START, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        step(1'b1);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        send(qpdpc_pkg::FUNC_TICK, 1'b0, 1'b0);
        calm = 1'b0;

        // Random moves: target near the count, mostly well-formed quadrature steps
        picked = 0;
        while (picked < RANDOM_ITEMS) begin
            goal = int'($signed(board.count)) + int'($urandom_range(80, 0)) - 40;
            if (goal > 32767) goal = 32767;
            if (goal < -32768) goal = -32768;
            if ($urandom_range(7, 0) == 0) goal = int'($urandom_range(65535, 0)) - 32768;
            configure(goal[qpdpc_pkg::REF_W-1:0], pick_gain(), pick_gain(), pick_duty(),
                      pick_duty());
            calm = ($urandom_range(3, 0) == 0);
            send(qpdpc_pkg::FUNC_START, coin(), coin());
            repeat ($urandom_range(60, 20)) begin
                roll = int'($urandom_range(99, 0));
                if (roll < 8) begin
                    send(qpdpc_pkg::FUNC_SAMPLE, coin(), coin());
                end else if (roll < 11) begin
                    send(qpdpc_pkg::FUNC_UNUSED, coin(), coin());
                end else if (roll < 14) begin
                    send(qpdpc_pkg::FUNC_START, coin(), coin());
                end else if (roll < 40 || board.count == target_pos) begin
                    send(qpdpc_pkg::FUNC_TICK, coin(), coin());
                end else begin
                    // step toward the target, now and then away from it
                    step(($signed(board.count) < target_pos) ^ (roll >= 94));
                end
                picked++;
            end
        end
        calm = 1'b0;

        // Drain, then watch for stray beats
        settle();
        repeat (16) @(posedge i_clk);
        if (board.faults == 0 && board.due_status.size() == 0) begin
            $display("** quadrature_pd_position_controller: PASSED **");
        end else begin
            $display("** quadrature_pd_position_controller: FAILED **");
        end
        $finish;
    end

endmodule
